>>> hw/rtl/wbpm_pkg.sv
// ----------------------------------------------------------------------------
// wbpm_pkg
// shared types and constants for the wildcard byte pattern matcher
// ----------------------------------------------------------------------------
package wbpm_pkg;

    localparam int PATTERN_MAX_DEFAULT = 256;
    localparam int LEN_W               = 9;
    localparam int OFFSET_W            = 32;
    localparam int BYTE_W              = 8;

    localparam logic [LEN_W-1:0]  LEN_RESET = 9'd1;
    localparam logic [BYTE_W-1:0] WILDCARD  = 8'h00;

    // word modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_SCAN = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [BYTE_W-1:0] byte_value;
        logic [7:0]        pattern_index;
        logic              first_of_data;
        logic              last_of_data;
    } in_word_t;

    typedef struct packed {
        logic                match_found;
        logic [OFFSET_W-1:0] match_offset;
    } out_word_t;

    // one processed word as seen by the cell array and the scan control
    typedef struct packed {
        logic              load_en;
        logic              scan_en;
        logic              first_of_data;
        logic              last_of_data;
        logic [BYTE_W-1:0] byte_value;
        logic [7:0]        pattern_index;
    } step_t;

endpackage

>>> hw/rtl/wbpm_cell_array.sv
// ----------------------------------------------------------------------------
// wbpm_cell_array
// pattern store and per-cell shift-and history, one compare per cell
// ----------------------------------------------------------------------------
module wbpm_cell_array #(
    parameter int PATTERN_MAX = wbpm_pkg::PATTERN_MAX_DEFAULT,
    localparam int IDX_W = $clog2(PATTERN_MAX),
    localparam int CMP_W = (IDX_W + 1 > wbpm_pkg::LEN_W) ? IDX_W + 1 : wbpm_pkg::LEN_W
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  wbpm_pkg::step_t     step,
    input  logic [IDX_W-1:0]    tail_sel,
    output logic                tail_hit
);

    logic [wbpm_pkg::BYTE_W-1:0] pattern_reg [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]      partial_reg;
    logic [PATTERN_MAX-1:0]      partial_next;
    logic [PATTERN_MAX-1:0]      hits;
    logic [CMP_W-1:0]            idx_ext;
    logic                        load_hit;

    assign idx_ext  = CMP_W'(step.pattern_index);
    assign load_hit = step.load_en && (idx_ext < CMP_W'(PATTERN_MAX));

    // store is undefined until written, so no reset
    always_ff @(posedge aclk) begin
        if (load_hit) begin
            pattern_reg[idx_ext[IDX_W-1:0]] <= step.byte_value;
        end
    end

    always_comb begin
        for (int j = 0; j < PATTERN_MAX; j++) begin
            hits[j] = (pattern_reg[j] == wbpm_pkg::WILDCARD) ||
                      (pattern_reg[j] == step.byte_value);
        end
    end

    // first word of a buffer starts from an empty history
    always_comb begin
        partial_next[0] = hits[0];
        for (int j = 1; j < PATTERN_MAX; j++) begin
            partial_next[j] = (step.first_of_data ? 1'b0 : partial_reg[j-1]) & hits[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
        end else if (step.scan_en) begin
            partial_reg <= partial_next;
        end
    end

    assign tail_hit = partial_next[tail_sel];

endmodule

>>> hw/rtl/wbpm_scan_ctrl.sv
// ----------------------------------------------------------------------------
// wbpm_scan_ctrl
// byte position, reported flag and result word formation
// ----------------------------------------------------------------------------
module wbpm_scan_ctrl #(
    parameter int PATTERN_MAX = wbpm_pkg::PATTERN_MAX_DEFAULT,
    localparam int IDX_W = $clog2(PATTERN_MAX),
    localparam int CMP_W = (IDX_W + 1 > wbpm_pkg::LEN_W) ? IDX_W + 1 : wbpm_pkg::LEN_W
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wbpm_pkg::step_t               step,
    input  logic [wbpm_pkg::LEN_W-1:0]    pattern_length,
    input  logic                          tail_hit,
    output logic [IDX_W-1:0]              tail_sel,
    output logic                          res_valid,
    output wbpm_pkg::out_word_t           res_word
);

    localparam logic [wbpm_pkg::OFFSET_W-1:0] POS_MAX = '1;

    logic [wbpm_pkg::OFFSET_W-1:0] position_reg;
    logic [wbpm_pkg::OFFSET_W-1:0] position_next;
    logic                          reported_reg;
    logic                          reported_next;
    logic [CMP_W-1:0]              len_ext;
    logic [CMP_W-1:0]              len_eff;
    logic [CMP_W-1:0]              len_m1;
    logic [wbpm_pkg::OFFSET_W-1:0] len_m1_wide;
    logic [wbpm_pkg::OFFSET_W-1:0] here;
    logic                          reported_cur;

    // zero length acts as one, oversize clamps to the store depth
    always_comb begin
        len_ext = CMP_W'(pattern_length);
        if (len_ext == '0) begin
            len_eff = CMP_W'(1);
        end else if (len_ext > CMP_W'(PATTERN_MAX)) begin
            len_eff = CMP_W'(PATTERN_MAX);
        end else begin
            len_eff = len_ext;
        end
        len_m1      = len_eff - CMP_W'(1);
        len_m1_wide = wbpm_pkg::OFFSET_W'(len_m1);
    end

    assign tail_sel = len_m1[IDX_W-1:0];

    always_comb begin
        here          = step.first_of_data ? '0 : position_reg;
        reported_cur  = step.first_of_data ? 1'b0 : reported_reg;
        res_valid     = 1'b0;
        res_word      = '0;
        position_next = position_reg;
        reported_next = reported_reg;
        if (step.scan_en) begin
            position_next = (here == POS_MAX) ? here : here + 1'b1;
            if (!reported_cur) begin
                if (tail_hit) begin
                    res_valid            = 1'b1;
                    res_word.match_found = 1'b1;
                    res_word.match_offset = (here >= len_m1_wide) ? here - len_m1_wide : '0;
                end else if (step.last_of_data) begin
                    res_valid = 1'b1;
                end
            end
            reported_next = reported_cur | res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            reported_reg <= 1'b0;
        end else begin
            position_reg <= position_next;
            reported_reg <= reported_next;
        end
    end

endmodule

>>> hw/rtl/wildcard_byte_pattern_matcher.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_matcher
// streaming first-match search of a stored byte pattern with 0x00 wildcards
// ----------------------------------------------------------------------------
// The block takes one word per clock while the input side is not stalled, and
// registers each result word once the result register is free. A word is
// either a pattern load (mode 0, written to the
// cell at pattern_index, ignored at or past the store depth) or a data byte
// (mode 1). Each data byte is compared against every pattern cell at once in
// a single stage between the input register and the result register; that
// one compare-and-shift stage across all cells sets the rate of one word per
// cycle. A result word comes out on the first match of a buffer (its start
// offset) or, if nothing matched, on the byte marked last (not found, offset
// zero); after that the buffer stays quiet until the next first mark. Load
// pattern cells before using them and write pattern_length only while the
// block is idle. While a result word waits on m_ready, one more word still
// enters the input register; the input side stalls only once that word is
// held as well.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_matcher #(
    parameter int PATTERN_MAX = wbpm_pkg::PATTERN_MAX_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // pattern length register
    input  logic                          cfg_wr_en,
    input  logic [wbpm_pkg::LEN_W-1:0]    cfg_wr_data,
    // input words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  wbpm_pkg::in_word_t            s_data,
    // result words
    output logic                          m_valid,
    input  logic                          m_ready,
    output wbpm_pkg::out_word_t           m_data
);

    localparam int IDX_W = $clog2(PATTERN_MAX);

    // config register
    logic [wbpm_pkg::LEN_W-1:0] len_reg;

    // input register stage
    logic                in_valid_reg;
    logic                in_valid_next;
    wbpm_pkg::in_word_t  in_word_reg;

    // result register stage
    logic                m_valid_reg;
    logic                m_valid_next;
    wbpm_pkg::out_word_t m_word_reg;

    // working signals
    logic                advance;
    logic                s_take;
    wbpm_pkg::step_t     step;
    logic [IDX_W-1:0]    tail_sel;
    logic                tail_hit;
    logic                res_valid;
    wbpm_pkg::out_word_t res_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= wbpm_pkg::LEN_RESET;
        end else if (cfg_wr_en) begin
            len_reg <= cfg_wr_data;
        end
    end

    // the held word moves on whenever the result register can take its outcome
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_word_reg <= s_data;
        end
    end

    // first and last marks only matter on data bytes
    always_comb begin
        step.load_en       = advance && (in_word_reg.mode == wbpm_pkg::MODE_LOAD);
        step.scan_en       = advance && (in_word_reg.mode == wbpm_pkg::MODE_SCAN);
        step.first_of_data = in_word_reg.first_of_data;
        step.last_of_data  = in_word_reg.last_of_data;
        step.byte_value    = in_word_reg.byte_value;
        step.pattern_index = in_word_reg.pattern_index;
    end

    wbpm_cell_array #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cells (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .tail_sel (tail_sel),
        .tail_hit (tail_hit)
    );

    wbpm_scan_ctrl #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (step),
        .pattern_length (len_reg),
        .tail_hit       (tail_hit),
        .tail_sel       (tail_sel),
        .res_valid      (res_valid),
        .res_word       (res_word)
    );

    // result register: loads on every advance, drains on m_ready otherwise
    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = res_valid;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            m_word_reg <= res_word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_word_reg;

endmodule

>>> hw/rtl/wbpm_checker.sv
// ----------------------------------------------------------------------------
// wbpm_checker
// port-level checks for the wildcard byte pattern matcher
// ----------------------------------------------------------------------------
module wbpm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input wbpm_pkg::in_word_t            s_data,
    input logic                          m_valid,
    input logic                          m_ready,
    input wbpm_pkg::out_word_t           m_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // reset empties the result side
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input side is never blocked while the result side can drain
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled with free result register");

    // a fresh result follows an accepted data byte through the input and result registers
    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |->
            $past(s_valid && s_ready && (s_data.mode == wbpm_pkg::MODE_SCAN), 2))
        else $error("result without a data byte");

    // not-found results carry a zero offset
    a_notfound_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.match_found |-> (m_data.match_offset == '0))
        else $error("not-found result with nonzero offset");

endmodule

bind wildcard_byte_pattern_matcher wbpm_checker u_wbpm_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_data      (s_data),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_data      (m_data)
);

>>> bench/wbpm_match_checker.sv
// ----------------------------------------------------------------------------
// wbpm_match_checker
// predicts the result words of the pattern matcher and compares them as they
// leave the block
// ----------------------------------------------------------------------------
module wbpm_match_checker #(
    parameter int PATTERN_MAX = wbpm_pkg::PATTERN_MAX_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [wbpm_pkg::LEN_W-1:0] cfg_wr_data,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  wbpm_pkg::in_word_t         s_data,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  wbpm_pkg::out_word_t        m_data,
    output int                         error_count,
    output int                         results_pending
);

    logic [wbpm_pkg::BYTE_W-1:0]   pattern_cells [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]        hist_bits;
    logic [wbpm_pkg::OFFSET_W-1:0] scan_pos;
    logic                          buffer_done;
    logic [wbpm_pkg::LEN_W-1:0]    length_reg;
    wbpm_pkg::out_word_t           expected_results [$];
    int                            errors = 0;

    function automatic int unsigned active_len();
        if (length_reg == '0) return 1;
        if (int'(length_reg) > PATTERN_MAX) return PATTERN_MAX;
        return 32'(length_reg);
    endfunction

    // one accepted word: update the model state, queue a result if one is due
    function automatic void predict_word(input wbpm_pkg::in_word_t w);
        logic [PATTERN_MAX-1:0]        hits;
        logic [wbpm_pkg::OFFSET_W-1:0] here;
        int unsigned                   len;
        wbpm_pkg::out_word_t           res;
        if (w.mode == wbpm_pkg::MODE_LOAD) begin
            if (int'(w.pattern_index) < PATTERN_MAX)
                pattern_cells[w.pattern_index] = w.byte_value;
            return;
        end
        if (w.first_of_data) begin
            hist_bits   = '0;
            scan_pos    = '0;
            buffer_done = 1'b0;
        end
        for (int j = 0; j < PATTERN_MAX; j++)
            hits[j] = (pattern_cells[j] == wbpm_pkg::WILDCARD) ||
                      (pattern_cells[j] == w.byte_value);
        hist_bits = {hist_bits[PATTERN_MAX-2:0], 1'b1} & hits;
        here = scan_pos;
        if (scan_pos != '1)
            scan_pos = scan_pos + 1'b1;
        if (buffer_done)
            return;
        len = active_len();
        if (hist_bits[len-1]) begin
            res.match_found  = 1'b1;
            res.match_offset = (here >= len - 1) ? here - (len - 1) : '0;
            expected_results = {expected_results, res};
            buffer_done = 1'b1;
        end else if (w.last_of_data) begin
            res = '0;
            expected_results = {expected_results, res};
            buffer_done = 1'b1;
        end
    endfunction

    initial begin
        foreach (pattern_cells[i])
            pattern_cells[i] = wbpm_pkg::WILDCARD;
    end

    always @(posedge aclk) begin
        wbpm_pkg::out_word_t want;
        if (!aresetn) begin
            hist_bits   = '0;
            scan_pos    = '0;
            buffer_done = 1'b0;
            length_reg  = wbpm_pkg::LEN_RESET;
            expected_results.delete();
        end else begin
            // results leave only after their word has passed the input register, so compare first
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result word with none expected: match_found=%0b match_offset=%0d",
                           m_data.match_found, m_data.match_offset);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.match_found !== want.match_found) begin
                        $error("match_found: expected %0b, actual %0b",
                               want.match_found, m_data.match_found);
                        errors++;
                    end
                    if (m_data.match_offset !== want.match_offset) begin
                        $error("match_offset: expected %0d, actual %0d",
                               want.match_offset, m_data.match_offset);
                        errors++;
                    end
                end
            end
            if (cfg_wr_en)
                length_reg = cfg_wr_data;
            if (s_valid && s_ready)
                predict_word(s_data);
        end
        error_count     <= errors;
        results_pending <= expected_results.size();
    end

endmodule

>>> bench/wildcard_byte_pattern_matcher_tb.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_matcher_tb
// stimulus and verdict for the wildcard byte pattern matcher
// ----------------------------------------------------------------------------
// Fills the whole pattern store, runs a short directed sequence over the
// corner cases, then a series of phases with different pattern lengths in
// which buffers mostly carry a planted copy of the pattern, with noise and
// near misses mixed in. A checker beside the block predicts and compares
// every result word; this module only drives the ports and gives the verdict.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_matcher_tb;

    localparam int PATTERN_MAX   = wbpm_pkg::PATTERN_MAX_DEFAULT;
    localparam int SETTLE_CYCLES = 6;
    localparam int SHORT_BUDGET  = 12;  // words per phase with a short pattern
    localparam int NUM_PHASES    = 10;
    localparam int unsigned PHASE_LENGTHS [NUM_PHASES] = '{2, 1, 4, 8, 256, 3, 511, 5, 16, 2};

    // buffer kinds
    localparam int KIND_PLANTED   = 0;
    localparam int KIND_NOISE     = 1;
    localparam int KIND_NEAR_MISS = 2;

    logic                         aclk        = 1'b0;
    logic                         aresetn     = 1'b0;
    logic                         cfg_wr_en   = 1'b0;
    logic [wbpm_pkg::LEN_W-1:0]   cfg_wr_data = '0;
    logic                         s_valid     = 1'b0;
    logic                         s_ready;
    wbpm_pkg::in_word_t           s_data      = '0;
    logic                         m_valid;
    logic                         m_ready     = 1'b0;
    wbpm_pkg::out_word_t          m_data;

    int                           error_count;
    int                           results_pending;

    // what the sender has put into the pattern store, used to plant matches
    logic [wbpm_pkg::BYTE_W-1:0]  pat_mirror [PATTERN_MAX];
    int                           words_sent = 0;
    int                           idle_pct   = 14;
    int                           stall_pct  = 49;

    always #5 aclk = ~aclk;

    wildcard_byte_pattern_matcher #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    wbpm_match_checker #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .error_count     (error_count),
        .results_pending (results_pending)
    );

    // receiver stalls at random, rate set by the current phase
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // present one word, with random idle cycles ahead of it, and hold it
    // until the block takes it
    task automatic push_word(input wbpm_pkg::in_word_t w);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        if (w.mode == wbpm_pkg::MODE_LOAD)
            pat_mirror[w.pattern_index] = w.byte_value;
        words_sent++;
    endtask

    // marks on a load are ignored by the block, so they are random here
    task automatic load_cell(input logic [7:0] idx, input logic [wbpm_pkg::BYTE_W-1:0] value);
        push_word('{mode: wbpm_pkg::MODE_LOAD, byte_value: value, pattern_index: idx,
                    first_of_data: 1'($urandom), last_of_data: 1'($urandom)});
    endtask

    // pattern_index is unused on a data byte, so it carries random bits
    task automatic scan_byte(input logic [wbpm_pkg::BYTE_W-1:0] b, input logic first,
                             input logic last);
        push_word('{mode: wbpm_pkg::MODE_SCAN, byte_value: b, pattern_index: 8'($urandom),
                    first_of_data: first, last_of_data: last});
    endtask

    // stop sending and wait until every expected result word has come out
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // the length register is written only with the block idle
    task automatic set_length(input logic [wbpm_pkg::LEN_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // background byte: often one of the pattern bytes, so partial matches
    // build up and break off
    function automatic logic [wbpm_pkg::BYTE_W-1:0] noise_byte(input int unsigned plen);
        logic [wbpm_pkg::BYTE_W-1:0] pick;
        if ($urandom_range(0, 99) < 40)
            return 8'($urandom);
        pick = pat_mirror[$urandom_range(0, plen - 1)];
        return (pick == wbpm_pkg::WILDCARD) ? 8'($urandom) : pick;
    endfunction

    // one buffer of blen data bytes; planted and near-miss kinds carry a copy
    // of the pattern at a random offset if blen >= plen, wildcard cells filled with noise
    task automatic send_buffer(input int unsigned plen, input int unsigned blen, input int kind,
                               input logic with_first, input logic with_last,
                               input logic allow_loads);
        logic [wbpm_pkg::BYTE_W-1:0] data_q [];
        int unsigned                 at;
        int unsigned                 k;
        data_q = new[blen];
        for (int i = 0; i < blen; i++)
            data_q[i] = noise_byte(plen);
        if (kind != KIND_NOISE && blen >= plen) begin
            at = $urandom_range(0, blen - plen);
            for (int i = 0; i < plen; i++)
                if (pat_mirror[i] != wbpm_pkg::WILDCARD)
                    data_q[at + i] = pat_mirror[i];
            // near miss: break the picked cell of the copy if it is a literal
            if (kind == KIND_NEAR_MISS) begin
                k = $urandom_range(0, plen - 1);
                if (pat_mirror[k] != wbpm_pkg::WILDCARD)
                    data_q[at + k] = pat_mirror[k] ^ 8'h01;
            end
        end
        for (int i = 0; i < blen; i++) begin
            // a load in the middle of a scan takes effect at once
            if (allow_loads && $urandom_range(0, 99) < 4)
                load_cell(8'($urandom), 8'($urandom));
            scan_byte(data_q[i], with_first && i == 0, with_last && i == blen - 1);
        end
    endtask

    initial begin
        int unsigned plen;
        int unsigned blen;
        int          roll;
        int          kind;
        int          phase_start;

        // reset held at the start, never again
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fill every store cell so no scan ever reads an unwritten one
        for (int i = 0; i < PATTERN_MAX; i++)
            load_cell(8'(i), ($urandom_range(0, 99) < 70) ? wbpm_pkg::WILDCARD
                                                          : 8'($urandom_range(1, 255)));

        // ---------------- directed part ----------------
        set_length(wbpm_pkg::LEN_RESET);
        scan_byte(8'h00, 1'b0, 1'b0);        // byte with no first mark after reset
        scan_byte(8'h5a, 1'b1, 1'b1);        // one-byte buffer, single wildcard-or-literal cell
        set_length(9'd3);
        load_cell(8'd0, 8'hff);
        load_cell(8'd1, wbpm_pkg::WILDCARD);
        load_cell(8'd2, 8'h01);
        load_cell(8'd255, pat_mirror[255]);  // top cell, marks set at random
        // match at offset zero, the wildcard taking a literal zero
        scan_byte(8'hff, 1'b1, 1'b0);
        scan_byte(8'h00, 1'b0, 1'b0);
        scan_byte(8'h01, 1'b0, 1'b0);
        // already reported: no further result in this buffer
        scan_byte(8'hff, 1'b0, 1'b0);
        scan_byte(8'h01, 1'b0, 1'b1);
        // data shorter than the pattern
        scan_byte(8'hff, 1'b1, 1'b1);
        // pattern cell rewritten during the scan
        scan_byte(8'h12, 1'b1, 1'b0);
        scan_byte(8'hff, 1'b0, 1'b0);
        scan_byte(8'h55, 1'b0, 1'b0);
        load_cell(8'd2, 8'h07);
        scan_byte(8'h07, 1'b0, 1'b1);
        // no match up to the last byte
        scan_byte(8'h01, 1'b1, 1'b0);
        scan_byte(8'h02, 1'b0, 1'b0);
        scan_byte(8'h03, 1'b0, 1'b1);
        // length zero behaves as one
        set_length('0);
        scan_byte(8'hfe, 1'b1, 1'b0);
        scan_byte(8'hff, 1'b0, 1'b1);

        // ---------------- random phases ----------------
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph < 4) begin
                idle_pct  = 14;
                stall_pct = 49;
            end else if (ph < 7) begin
                idle_pct  = 49;
                stall_pct = 14;
            end else begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            set_length(wbpm_pkg::LEN_W'(PHASE_LENGTHS[ph]));
            plen = (PHASE_LENGTHS[ph] > PATTERN_MAX) ? PATTERN_MAX : PHASE_LENGTHS[ph];
            // new head of the pattern; cells past it keep what they held
            for (int i = 0; i < ((plen < 8) ? plen : 8); i++)
                load_cell(8'(i), ($urandom_range(0, 99) < 25) ? wbpm_pkg::WILDCARD
                                                              : 8'($urandom));

            if (plen >= 200) begin
                // full-depth pattern: one long planted buffer, one too short
                send_buffer(plen, plen + $urandom_range(0, 3), KIND_PLANTED, 1'b1, 1'b1, 1'b0);
                send_buffer(plen, $urandom_range(1, 12), KIND_NOISE, 1'b1, 1'b1, 1'b0);
            end else begin
                phase_start = words_sent;
                while (words_sent - phase_start < SHORT_BUDGET) begin
                    blen = $urandom_range(1, 3 * plen + 6);
                    roll = $urandom_range(0, 99);
                    kind = (roll < 70) ? KIND_PLANTED : (roll < 85) ? KIND_NOISE
                                                                     : KIND_NEAR_MISS;
                    // some buffers run on without a first or a last mark
                    send_buffer(plen, blen, kind, $urandom_range(0, 99) < 92,
                                $urandom_range(0, 99) < 90, 1'b1);
                    // sender holds off once until the block has emptied
                    if (ph == 7 && words_sent - phase_start >= SHORT_BUDGET / 2
                        && words_sent - phase_start < SHORT_BUDGET / 2 + blen)
                        drain_results();
                end
            end
        end

        // ---------------- wind-down and verdict ----------------
        drain_results();
        if (error_count == 0 && results_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // run limit, far past the slowest correct run
    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/wbpm_pkg.sv
hw/rtl/wbpm_cell_array.sv
hw/rtl/wbpm_scan_ctrl.sv
hw/rtl/wildcard_byte_pattern_matcher.sv
hw/rtl/wbpm_checker.sv
bench/wbpm_match_checker.sv
bench/wildcard_byte_pattern_matcher_tb.sv
